// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold while out of reset
`define ASSERT_ON(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("assertion failed");

// property must hold at every edge
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

// ===== sv/fhyp_pkg.sv =====
// ----------------------------------------------------------------------------
// fhyp_pkg
// shared types and constants of the single-precision hypotenuse unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fhyp_pkg;

  localparam logic [31:0] InfBits  = 32'h7F80_0000;
  localparam logic [31:0] QnanBits = 32'h7FC0_0000;
  localparam logic [31:0] AbsMask  = 32'h7FFF_FFFF;

  // classification decided in the front end
  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_INF    = 2'd1,
    KIND_NAN    = 2'd2,
    KIND_ZERO   = 2'd3
  } kind_e;

  // one classified request as held in the queue
  typedef struct packed {
    kind_e       kind;
    logic [30:0] m_bits;
    logic [30:0] n_bits;
  } front_req_t;

  // unpacked finite float: value = sig * 2^(exp - 23 - 127), sig has leading one
  typedef struct packed {
    logic signed [9:0] exp;
    logic [23:0]       sig;
  } unp_t;

  function automatic unp_t unpack(input logic [30:0] b);
    unp_t u;
    logic [4:0] lz;
    logic [23:0] s;
    begin
      u = '0;
      lz = '0;
      if (b[30:23] != 8'd0) begin
        u.exp = $signed({2'b00, b[30:23]});
        u.sig = {1'b1, b[22:0]};
      end else begin
        s = {1'b0, b[22:0]};
        for (int i = 23; i >= 0; i--) begin
          if (s[i] && lz == 5'd0 && (s >> i) == 24'd1) lz = 5'(23 - i);
        end
        u.sig = s << lz;
        u.exp = 10'sd1 - $signed({5'd0, lz});
      end
      return u;
    end
  endfunction

  // round a significand with value sig * 2^(exp-127-24) plus guard/sticky
  // sig holds 25 bits: leading one at bit 24, round bit at bit 0
  // input: mantissa m[24:0] with leading one at bit 24 (i.e. 1.x with 24 frac)
  // plus sticky; exp is the biased exponent for the leading one
  function automatic logic [30:0] round_pack(input logic signed [9:0] exp,
                                             input logic [24:0] m,
                                             input logic sticky);
    logic [49:0] w;
    logic [5:0]  sh;
    logic [24:0] keep;
    logic        rb, st, lsb;
    logic [24:0] rnd;
    logic [30:0] r;
    begin
      if (exp >= 10'sd1) begin
        w = {m, 25'd0};
        sh = 6'd0;
      end else begin
        sh = (exp < -10'sd30) ? 6'd31 : 6'(10'sd1 - exp);
        w = {m, 25'd0} >> sh;
      end
      keep = {1'b0, w[49:26]};
      rb   = w[25];
      st   = sticky | (w[24:0] != 25'd0);
      if (exp < 10'sd1 && sh != 6'd0) st = st | (({m, 25'd0} & ((50'd1 << sh) - 50'd1)) != 0);
      lsb  = keep[0];
      rnd  = keep + {24'd0, rb & (st | lsb)};
      if (exp >= 10'sd1) begin
        if (rnd[24]) begin
          if (exp + 10'sd1 >= 10'sd255) r = InfBits[30:0];
          else r = {8'(exp + 10'sd1), 23'd0};
        end else if (exp >= 10'sd255) r = InfBits[30:0];
        else r = {exp[7:0], rnd[22:0]};
      end else begin
        r = {7'd0, rnd[23:0]};
      end
      return r;
    end
  endfunction

endpackage

// ===== sv/fhyp_front.sv =====
// ----------------------------------------------------------------------------
// fhyp_front
// accepts operand pairs, orders magnitudes and classifies special cases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fhyp_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [31:0]            x_bits_i,
  input  logic [31:0]            y_bits_i,
  output logic                   req_valid_o,
  input  logic                   req_stall_i,
  output fhyp_pkg::front_req_t   req_o
);
  import fhyp_pkg::*;

  logic [30:0] ax, ay;
  front_req_t  cls;
  logic        valid_q;
  front_req_t  req_q;

  // classify
  always_comb begin
    ax = x_bits_i[30:0];
    ay = y_bits_i[30:0];
    cls.m_bits = (ax > ay) ? ax : ay;
    cls.n_bits = (ax > ay) ? ay : ax;
    if (ax == InfBits[30:0] || ay == InfBits[30:0]) cls.kind = KIND_INF;
    else if (ax > InfBits[30:0] || ay > InfBits[30:0]) cls.kind = KIND_NAN;
    else if (cls.m_bits == 31'd0) cls.kind = KIND_ZERO;
    else cls.kind = KIND_NORMAL;
  end

  assign in_stall    = valid_q && req_stall_i;
  assign req_valid_o = valid_q;
  assign req_o       = req_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall && in_valid) begin
      req_q <= cls;
    end
  end

endmodule

// ===== sv/fhyp_queue.sv =====
// ----------------------------------------------------------------------------
// fhyp_queue
// short fifo between the front end and the arithmetic pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fhyp_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  output logic                 wr_stall_o,
  input  fhyp_pkg::front_req_t wr_data_i,
  output logic                 rd_valid_o,
  input  logic                 rd_stall_i,
  output fhyp_pkg::front_req_t rd_data_o
);
  import fhyp_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  front_req_t       mem_q [Depth];
  logic [Aw-1:0]    wp_q, rp_q;
  logic [Aw:0]      cnt_q;
  logic             push, pop;

  assign wr_stall_o = (cnt_q == (Aw+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && !wr_stall_o;
  assign pop  = rd_valid_o && !rd_stall_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

endmodule

// ===== sv/fhyp_back.sv =====
// ----------------------------------------------------------------------------
// fhyp_back
// pipelined divide, square, add, square root and multiply
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fhyp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_stall_o,
  input  fhyp_pkg::front_req_t req_i,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          result_bits_o
);
  import fhyp_pkg::*;

  // stages: 0 unpack, 1..26 division, 27 round q, 28 square,
  // 29 round sq, 30 add, 31 root setup, 32..56 root, 57 round r, 58 mult,
  // then the output register rounds the product
  localparam int DivSteps = 26;
  localparam int RootSteps = 25;
  localparam int NStg = 59;

  logic adv;
  logic [NStg-1:0] v_q;
  logic [31:0] res_q;
  logic        res_v_q;

  assign adv = !(res_v_q && out_stall);
  assign req_stall_o = !adv;
  assign out_valid = res_v_q;
  assign result_bits_o = res_q;

  // control shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      res_v_q <= 1'b0;
    end else if (adv) begin
      v_q <= {v_q[NStg-2:0], req_valid_i};
      res_v_q <= v_q[NStg-1];
    end
  end

  // carried payload
  kind_e       kind_q [NStg];
  unp_t        mu_q   [NStg];

  // division state: quotient of n_sig / m_sig bits
  logic [25:0] rem_q [DivSteps+1];
  logic [25:0] quo_q [DivSteps+1];
  logic signed [9:0] qe_q [DivSteps+1];
  logic [23:0] dsr_q [DivSteps+1];

  unp_t nu, mu0;
  assign nu  = unpack(req_i.n_bits);
  assign mu0 = unpack(req_i.m_bits);

  // t value after rounding, then later values
  logic [30:0] t_q, sq_q, s_q, r_q;
  logic [47:0] prod_q;
  logic signed [9:0] pe_q;
  logic [47:0] prod2_q;
  logic signed [9:0] pe2_q;

  // root state
  logic [49:0] rv_q [RootSteps+1];
  logic [49:0] rr_q [RootSteps+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_q[0] <= req_i.kind;
      mu_q[0]   <= mu0;
      for (int i = 1; i < NStg; i++) begin
        kind_q[i] <= kind_q[i-1];
        mu_q[i]   <= mu_q[i-1];
      end
      // divide setup: normalise so n_sig >= m_sig
      if (nu.sig >= mu0.sig) begin
        rem_q[0] <= {2'b0, nu.sig};
        qe_q[0]  <= nu.exp - mu0.exp + 10'sd127;
      end else begin
        rem_q[0] <= {1'b0, nu.sig, 1'b0};
        qe_q[0]  <= nu.exp - mu0.exp + 10'sd126;
      end
      quo_q[0] <= '0;
      dsr_q[0] <= mu0.sig;
      // restoring division, one bit a stage
      for (int i = 0; i < DivSteps; i++) begin
        if (rem_q[i] >= {2'b0, dsr_q[i]}) begin
          rem_q[i+1] <= (rem_q[i] - {2'b0, dsr_q[i]}) << 1;
          quo_q[i+1] <= {quo_q[i][24:0], 1'b1};
        end else begin
          rem_q[i+1] <= rem_q[i] << 1;
          quo_q[i+1] <= {quo_q[i][24:0], 1'b0};
        end
        qe_q[i+1]  <= qe_q[i];
        dsr_q[i+1] <= dsr_q[i];
      end
      // round t: quo has leading one at bit 25, zero quotient means n is zero
      if (quo_q[DivSteps] == '0) t_q <= '0;
      else t_q <= round_pack(qe_q[DivSteps], quo_q[DivSteps][25:1],
                             quo_q[DivSteps][0] | (rem_q[DivSteps] != '0));
      // square t
      begin
        unp_t tu;
        tu = unpack(t_q);
        prod_q <= tu.sig * tu.sig;
        pe_q <= 10'sd2 * tu.exp - 10'sd127;
      end
      // round t*t
      if (prod_q == '0) sq_q <= '0;
      else if (prod_q[47]) sq_q <= round_pack(pe_q + 10'sd1, prod_q[47:23], prod_q[22:0] != 0);
      else sq_q <= round_pack(pe_q, prod_q[46:22], prod_q[21:0] != 0);
      // 1 + q, q <= 1
      begin
        unp_t qu;
        logic [9:0] d;
        logic [75:0] a;
        logic [75:0] bq;
        logic [75:0] sm;
        qu = unpack(sq_q);
        d = 10'(10'sd127 - qu.exp);
        a = {1'b0, 24'h800000, 51'd0};
        bq = (sq_q == 0 || d > 10'd74) ? 76'(sq_q != 0)
                                      : ({1'b0, qu.sig, 51'd0} >> d);
        sm = a + bq;
        if (sm[75]) s_q <= round_pack(10'sd128, sm[75:51], sm[50:0] != 0);
        else s_q <= round_pack(10'sd127, sm[74:50], sm[49:0] != 0);
      end
      // root setup
      rv_q[0] <= (s_q[30:23] > 8'd127) ? 50'(64'h800000) << 24
                                       : 50'({1'b1, s_q[22:0]}) << 23;
      rr_q[0] <= '0;
      // digit recurrence, one root bit per stage
      for (int i = 0; i < RootSteps; i++) begin
        logic [49:0] bt;
        bt = 50'd1 << (48 - 2*i);
        if (rv_q[i] >= rr_q[i] + bt) begin
          rv_q[i+1] <= rv_q[i] - (rr_q[i] + bt);
          rr_q[i+1] <= (rr_q[i] >> 1) + bt;
        end else begin
          rv_q[i+1] <= rv_q[i];
          rr_q[i+1] <= rr_q[i] >> 1;
        end
      end
      // round root
      r_q <= {8'd127, 23'(rr_q[RootSteps] + 50'(rv_q[RootSteps] > rr_q[RootSteps])
                        - 50'h800000)};
      // m * r
      prod2_q <= mu_q[NStg-2].sig * {1'b1, r_q[22:0]};
      pe2_q   <= mu_q[NStg-2].exp;
      // final rounding and special results
      case (kind_q[NStg-1])
        KIND_INF:  res_q <= InfBits;
        KIND_NAN:  res_q <= QnanBits;
        KIND_ZERO: res_q <= '0;
        default: begin
          if (prod2_q[47])
            res_q <= {1'b0, round_pack(pe2_q + 10'sd1, prod2_q[47:23], prod2_q[22:0] != 0)};
          else
            res_q <= {1'b0, round_pack(pe2_q, prod2_q[46:22], prod2_q[21:0] != 0)};
        end
      endcase
    end
  end

  `ASSERT_ON(a_stall_hold, clk_i, rst_ni, (out_valid && out_stall) |=> out_valid)
  `ASSERT_ON(a_hold_data, clk_i, rst_ni, (out_valid && out_stall) |=> $stable(result_bits_o))
  `ASSERT_ON(a_no_sign, clk_i, rst_ni, out_valid |-> !result_bits_o[31])

endmodule

// ===== sv/float32_hypotenuse.sv =====
// ----------------------------------------------------------------------------
// float32_hypotenuse
// single-precision hypotenuse sqrt(x*x + y*y), fully pipelined
// ----------------------------------------------------------------------------
// usage:
//   input channel  in_valid / in_stall carries x_bits_i and y_bits_i
//   output channel out_valid / out_stall carries result_bits_o
//   a request is taken at each edge with valid high and stall low
//   throughput: one request per cycle when the output is not stalled
//   path from the accepting edge to out_valid with the queue empty: front
//   register, queue write, 59 pipeline stages, output register
//   the front end orders and classifies magnitudes, a 4-entry queue
//   decouples it from the arithmetic pipeline
//   a stall on the output freezes the pipeline; the queue then fills and
//   in_stall rises once the front register can no longer drain
//   reset clears all valid flags; no clearing pass is needed
//   signs never affect the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module float32_hypotenuse #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] x_bits_i,
  input  logic [31:0] y_bits_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_bits_o
);
  import fhyp_pkg::*;

  logic       f_valid, f_stall, b_valid, b_stall;
  front_req_t f_req, b_req;

  fhyp_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .x_bits_i, .y_bits_i,
    .req_valid_o(f_valid), .req_stall_i(f_stall), .req_o(f_req)
  );

  fhyp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_data_i(f_req),
    .rd_valid_o(b_valid), .rd_stall_i(b_stall), .rd_data_o(b_req)
  );

  fhyp_back u_back (
    .clk_i, .rst_ni,
    .req_valid_i(b_valid), .req_stall_o(b_stall), .req_i(b_req),
    .out_valid, .out_stall, .result_bits_o
  );

endmodule
